// File: design/srci_pkg.sv
// Shared types, constants, sequencer states and helpers of the speed ramp integrator.
package srci_pkg;

  localparam int unsigned MAX_POINTS = 8;
  localparam int unsigned IDX_W      = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned TIME_W     = 24;
  localparam int unsigned SPD_W      = 22;
  localparam int unsigned OSPD_W     = 21;
  localparam int unsigned STEP_W     = 10;
  localparam int unsigned SRC_W      = 45;
  localparam int unsigned ACC_W      = 46;
  localparam int unsigned DNUM_W     = 40;
  localparam int unsigned DCNT_W     = 6;

  localparam logic [OSPD_W-1:0] ONE_Q16 = 21'd65536;
  localparam logic signed [23:0] SPEED_MIN = 24'sd3277;
  localparam logic signed [23:0] SPEED_MAX = 24'sd1310720;
  localparam logic [STEP_W-1:0] STEP_MAX = 10'd1000;
  localparam logic [17:0] THREE_Q16 = 18'd196608;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [1:0] {
    REG_ENABLE = 2'd0,
    REG_COUNT  = 2'd1,
    REG_STEP   = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [TIME_W-1:0] tm;
    logic [SPD_W-1:0]  spd;
  } key_t;

  localparam int unsigned ST_W = 34;

  typedef enum logic [ST_W-1:0] {
    S_IDLE   = 34'd1 << 0,
    S_RD0W   = 34'd1 << 1,
    S_RDL    = 34'd1 << 2,
    S_DN     = 34'd1 << 3,
    S_NS     = 34'd1 << 4,
    S_NSW    = 34'd1 << 5,
    S_VN     = 34'd1 << 6,
    S_FT     = 34'd1 << 7,
    S_F0     = 34'd1 << 8,
    S_C0     = 34'd1 << 9,
    S_CH     = 34'd1 << 10,
    S_KF     = 34'd1 << 11,
    S_MA     = 34'd1 << 12,
    S_MAW    = 34'd1 << 13,
    S_MB     = 34'd1 << 14,
    S_MBW    = 34'd1 << 15,
    S_KTM    = 34'd1 << 16,
    S_KTW    = 34'd1 << 17,
    S_LOOP   = 34'd1 << 18,
    S_TAILW  = 34'd1 << 19,
    S_ACC    = 34'd1 << 20,
    S_SUMD   = 34'd1 << 21,
    S_DW     = 34'd1 << 22,
    S_REM    = 34'd1 << 23,
    S_REMW   = 34'd1 << 24,
    S_OUT    = 34'd1 << 25,
    S_FCHK   = 34'd1 << 26,
    S_FSCAN  = 34'd1 << 27,
    S_FPREV  = 34'd1 << 28,
    S_FDIV   = 34'd1 << 29,
    S_FMUU   = 34'd1 << 30,
    S_FMW    = 34'd1 << 31,
    S_FMH    = 34'd1 << 32,
    S_FMS    = 34'd1 << 33
  } state_t;

  function automatic logic [OSPD_W-1:0] clamp_speed(input logic signed [23:0] v);
    logic [OSPD_W-1:0] r;
    if (v < SPEED_MIN) begin
      r = SPEED_MIN[OSPD_W-1:0];
    end else if (v > SPEED_MAX) begin
      r = SPEED_MAX[OSPD_W-1:0];
    end else begin
      r = v[OSPD_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: design/speed_ramp_curve_integrator_unit.sv
// Speed ramp integrator top level: sequencer, shared multiplier and datapath.
//
// Use: write keyframes with start high, op = 0 (point_index, point_time_ms,
// point_speed); the write takes effect at that edge and busy stays low.
// A query (start high, op = 1, query_time_ms, source_offset_ms) raises busy
// until the result: done pulses for one cycle with speed_now and
// source_time. Configuration goes through cfg_we / cfg_index / cfg_data;
// the user must write it only while the block is idle; the block does not enforce this.
// Sequence: with the curve off or no keyframes, a query goes straight to
// the output state. Otherwise a full speed evaluation does a keyframe scan
// of up to MAX_POINTS - 1 reads, a divide and the multiply steps S_FMUU,
// S_FMW and S_FMH; evaluations outside the keyframe span end at the range
// check. A query divides the query time by the step and evaluates at the
// last whole step and at the query time; with a nonzero step count it also
// divides the first keyframe time by the step and evaluates at 0, at the
// first and last keyframe and at every integration step strictly between.
// The shared divider and the single shared multiplier serve these in turn.
// Reset clears the sequencer and the registers (enable 0, count 0, step
// 10); keyframe slots hold nothing until written. The receiver cannot
// stall: done is a strobe, and a new start is taken while done is high.
module speed_ramp_curve_integrator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [2:0]  point_index,
  input  logic [23:0] point_time_ms,
  input  logic signed [21:0] point_speed,
  input  logic [23:0] query_time_ms,
  input  logic [23:0] source_offset_ms,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  output logic        done,
  output logic [20:0] speed_now,
  output logic [44:0] source_time
);
  import srci_pkg::*;

  state_t state, ret_state;

  logic              ramp_enable;
  logic [CNT_W-1:0]  point_count;
  logic [STEP_W-1:0] step_ms;

  logic [CNT_W-1:0]  n_act;
  logic [IDX_W-1:0]  last_idx;
  logic [STEP_W-1:0] s;

  logic              mem_we;
  logic [IDX_W-1:0]  raddr;
  key_t              wword, rword;

  logic              div_start, div_done;
  logic [DNUM_W-1:0] div_num, div_quot;
  logic [TIME_W-1:0] div_den, div_rmd;

  logic signed [47:0] mul_a;
  logic signed [25:0] mul_b;
  logic signed [73:0] mul_full;
  logic signed [63:0] prod;

  logic [TIME_W-1:0] qt, off, t0, tl, tj, eval_t, nsteps;
  logic signed [SPD_W-1:0] sp0, spl, sj, si;
  logic [STEP_W-1:0] remq;
  logic [IDX_W-1:0]  j;
  logic [16:0]       u;
  logic [OSPD_W-1:0] eval_res, vn, ft, f0, c0, chi;
  logic [24:0]       k, kt;
  logic [ACC_W-1:0]  acc, sum, d;

  logic signed [22:0] sdiff;
  logic signed [23:0] blend;
  logic [ACC_W-1:0]   dsum;

  assign busy     = (state != S_IDLE);
  assign n_act    = (point_count > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : point_count;
  assign last_idx = IDX_W'(n_act - 1'b1);
  assign s        = (step_ms == '0) ? STEP_W'(1) : ((step_ms > STEP_MAX) ? STEP_MAX : step_ms);
  assign sdiff    = 23'(sj) - 23'(si);
  assign blend    = 24'(si) + $signed(prod[39:16]);
  assign dsum     = {sum[ACC_W-2:0], 1'b0} - ACC_W'(f0) - ACC_W'(vn);
  assign mul_full = mul_a * mul_b;

  assign mem_we    = (state == S_IDLE) && start && (op == OP_WRITE);
  assign wword.tm  = point_time_ms;
  assign wword.spd = point_speed;

  srci_kmem u_kmem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (point_index),
    .wdata (wword),
    .raddr (raddr),
    .rdata (rword)
  );

  srci_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot),
    .rmd   (div_rmd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_enable <= 1'b0;
      point_count <= '0;
      step_ms     <= STEP_W'(10);
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ENABLE: ramp_enable <= cfg_data[0];
        REG_COUNT:  point_count <= cfg_data[CNT_W-1:0];
        REG_STEP:   step_ms     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    raddr     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = TIME_W'(1);
    mul_a     = '0;
    mul_b     = '0;
    unique case (state)
      S_RD0W:  raddr = last_idx;
      S_RDL: begin
        div_start = 1'b1;
        div_num   = DNUM_W'(qt);
        div_den   = TIME_W'(s);
      end
      S_CH: begin
        div_start = 1'b1;
        div_num   = DNUM_W'(t0);
        div_den   = TIME_W'(s);
      end
      S_FCHK:  raddr = IDX_W'(1);
      S_FSCAN: raddr = (rword.tm < eval_t) ? j + 1'b1 : j - 1'b1;
      S_FPREV: begin
        div_start = !(tj <= rword.tm || eval_t <= rword.tm);
        div_num   = {eval_t - rword.tm, 16'b0};
        div_den   = tj - rword.tm;
      end
      S_NS: begin
        mul_a = 48'(nsteps);
        mul_b = 26'(s);
      end
      S_MA: begin
        mul_a = 48'({1'b0, nsteps} + 25'd1);
        mul_b = 26'(c0);
      end
      S_MB: begin
        mul_a = 48'(div_quot[24:0] + 25'd1);
        mul_b = 26'(c0);
      end
      S_KTM: begin
        mul_a = 48'(k);
        mul_b = 26'(s);
      end
      S_LOOP: begin
        mul_a = 48'({1'b0, nsteps} - k + 25'd1);
        mul_b = 26'(chi);
      end
      S_SUMD: begin
        mul_a = 48'(dsum);
        mul_b = 26'(s);
      end
      S_REM: begin
        mul_a = 48'({1'b0, vn} + {1'b0, ft});
        mul_b = 26'(remq);
      end
      S_FMUU: begin
        mul_a = 48'(u);
        mul_b = 26'(u);
      end
      S_FMW: begin
        mul_a = 48'(prod[32:0]);
        mul_b = 26'(THREE_Q16 - {u, 1'b0});
      end
      S_FMH: begin
        mul_a = 48'(prod[48:32]);
        mul_b = 26'(sdiff);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_full[63:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret_state <= S_IDLE;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start && op == OP_QUERY) begin
            qt  <= query_time_ms;
            off <= source_offset_ms;
            if (ramp_enable && n_act != '0) begin
              state <= S_RD0W;
            end else begin
              ft    <= ONE_Q16;
              d     <= ACC_W'({query_time_ms, 17'b0});
              state <= S_OUT;
            end
          end
        end
        S_RD0W: begin
          t0    <= rword.tm;
          sp0   <= rword.spd;
          state <= S_RDL;
        end
        S_RDL: begin
          tl    <= rword.tm;
          spl   <= rword.spd;
          state <= S_DN;
        end
        S_DN: begin
          if (div_done) begin
            nsteps <= div_quot[TIME_W-1:0];
            remq   <= div_rmd[STEP_W-1:0];
            state  <= S_NS;
          end
        end
        S_NS:  state <= S_NSW;
        S_NSW: begin
          eval_t    <= prod[TIME_W-1:0];
          ret_state <= S_VN;
          state     <= S_FCHK;
        end
        S_VN: begin
          vn        <= eval_res;
          eval_t    <= qt;
          ret_state <= S_FT;
          state     <= S_FCHK;
        end
        S_FT: begin
          ft <= eval_res;
          if (nsteps == '0) begin
            d     <= '0;
            state <= S_REM;
          end else begin
            eval_t    <= '0;
            ret_state <= S_F0;
            state     <= S_FCHK;
          end
        end
        S_F0: begin
          f0        <= eval_res;
          eval_t    <= t0;
          ret_state <= S_C0;
          state     <= S_FCHK;
        end
        S_C0: begin
          c0        <= eval_res;
          eval_t    <= tl;
          ret_state <= S_CH;
          state     <= S_FCHK;
        end
        S_CH: begin
          chi   <= eval_res;
          state <= S_KF;
        end
        S_KF: begin
          if (div_done) begin
            state <= (div_quot >= DNUM_W'(nsteps)) ? S_MA : S_MB;
          end
        end
        S_MA:  state <= S_MAW;
        S_MAW: begin
          sum   <= prod[ACC_W-1:0];
          state <= S_SUMD;
        end
        S_MB: begin
          k     <= div_quot[24:0] + 25'd1;
          state <= S_MBW;
        end
        S_MBW: begin
          acc   <= prod[ACC_W-1:0];
          state <= S_KTM;
        end
        S_KTM: state <= S_KTW;
        S_KTW: begin
          kt    <= prod[24:0];
          state <= S_LOOP;
        end
        S_LOOP: begin
          if (k > {1'b0, nsteps}) begin
            sum   <= acc;
            state <= S_SUMD;
          end else if (kt >= {1'b0, tl}) begin
            state <= S_TAILW;
          end else begin
            eval_t    <= kt[TIME_W-1:0];
            ret_state <= S_ACC;
            state     <= S_FCHK;
          end
        end
        S_TAILW: begin
          sum   <= acc + prod[ACC_W-1:0];
          state <= S_SUMD;
        end
        S_ACC: begin
          acc   <= acc + ACC_W'(eval_res);
          k     <= k + 25'd1;
          kt    <= kt + 25'(s);
          state <= S_LOOP;
        end
        S_SUMD: state <= S_DW;
        S_DW: begin
          d     <= prod[ACC_W-1:0];
          state <= S_REM;
        end
        S_REM:  state <= (remq != '0) ? S_REMW : S_OUT;
        S_REMW: begin
          d     <= d + prod[ACC_W-1:0];
          state <= S_OUT;
        end
        S_OUT: begin
          done        <= 1'b1;
          speed_now   <= ft;
          source_time <= SRC_W'({off, 16'b0}) + d[ACC_W-1:1];
          state       <= S_IDLE;
        end
        S_FCHK: begin
          if (eval_t <= t0) begin
            eval_res <= clamp_speed(24'(sp0));
            state    <= ret_state;
          end else if (eval_t >= tl) begin
            eval_res <= clamp_speed(24'(spl));
            state    <= ret_state;
          end else begin
            j     <= IDX_W'(1);
            state <= S_FSCAN;
          end
        end
        S_FSCAN: begin
          if (rword.tm < eval_t) begin
            j <= j + 1'b1;
          end else begin
            tj    <= rword.tm;
            sj    <= rword.spd;
            state <= S_FPREV;
          end
        end
        S_FPREV: begin
          si <= rword.spd;
          if (tj <= rword.tm || eval_t <= rword.tm) begin
            eval_res <= clamp_speed(24'($signed(rword.spd)));
            state    <= ret_state;
          end else begin
            state <= S_FDIV;
          end
        end
        S_FDIV: begin
          if (div_done) begin
            u     <= (div_quot > DNUM_W'(65536)) ? 17'd65536 : div_quot[16:0];
            state <= S_FMUU;
          end
        end
        S_FMUU: state <= S_FMW;
        S_FMW:  state <= S_FMH;
        S_FMH:  state <= S_FMS;
        S_FMS: begin
          eval_res <= clamp_speed(blend);
          state    <= ret_state;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: design/srci_kmem.sv
// Keyframe store: one write port, one registered read port.
module srci_kmem (
  input  logic                      clk,
  input  logic                      we,
  input  logic [srci_pkg::IDX_W-1:0] waddr,
  input  srci_pkg::key_t             wdata,
  input  logic [srci_pkg::IDX_W-1:0] raddr,
  output srci_pkg::key_t             rdata
);
  import srci_pkg::*;

  key_t mem [MAX_POINTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/srci_div.sv
// Restoring divider, one quotient bit per cycle.
module srci_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [srci_pkg::DNUM_W-1:0] num,
  input  logic [srci_pkg::TIME_W-1:0] den,
  output logic                        done,
  output logic [srci_pkg::DNUM_W-1:0] quot,
  output logic [srci_pkg::TIME_W-1:0] rmd
);
  import srci_pkg::*;

  logic              running;
  logic [DCNT_W-1:0] cnt;
  logic [TIME_W-1:0] den_r;
  logic [TIME_W:0]   trial;

  assign trial = {rmd, quot[DNUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= DCNT_W'(DNUM_W);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == DCNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot  <= num;
      rmd   <= '0;
      den_r <= den;
    end else if (running) begin
      if (trial >= {1'b0, den_r}) begin
        rmd  <= TIME_W'(trial - {1'b0, den_r});
        quot <= {quot[DNUM_W-2:0], 1'b1};
      end else begin
        rmd  <= trial[TIME_W-1:0];
        quot <= {quot[DNUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

// File: bench/speed_ramp_curve_integrator_unit_test.sv
// Self-checking testbench of the speed ramp integrator: keyframe writes, queries, config phases.
`timescale 1ns / 100ps

module speed_ramp_curve_integrator_unit_test;
  import srci_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;

  typedef struct {
    logic [20:0] spd;
    logic [44:0] src;
  } ramp_result_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        op;
  logic [2:0]  point_index;
  logic [23:0] point_time_ms;
  logic signed [21:0] point_speed;
  logic [23:0] query_time_ms;
  logic [23:0] source_offset_ms;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [9:0]  cfg_data;
  logic        done;
  logic [20:0] speed_now;
  logic [44:0] source_time;

  longint unsigned key_tm [8];
  logic [21:0]     key_sp [8];
  logic            mdl_enable;
  logic [3:0]      mdl_count;
  logic [9:0]      mdl_step;

  ramp_result_t pending_results[$];
  int errors;
  int idle_pct;
  int stall_cycles;

  speed_ramp_curve_integrator_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .point_index(point_index), .point_time_ms(point_time_ms),
    .point_speed(point_speed), .query_time_ms(query_time_ms),
    .source_offset_ms(source_offset_ms), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .speed_now(speed_now),
    .source_time(source_time)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic longint unsigned limit_speed(longint v);
    if (v < 3277) return 3277;
    if (v > 1310720) return 1310720;
    return v;
  endfunction

  function automatic longint unsigned curve_speed(longint unsigned t, int n);
    int j;
    longint unsigned ti, tj, dt, u, u2, h;
    longint si, sj;
    if (t <= key_tm[0]) return limit_speed(longint'($signed(key_sp[0])));
    if (t >= key_tm[n-1]) return limit_speed(longint'($signed(key_sp[n-1])));
    j = 1;
    while (j < n && key_tm[j] < t) j++;
    if (j >= n) j = n - 1;
    ti = key_tm[j-1];
    tj = key_tm[j];
    si = longint'($signed(key_sp[j-1]));
    sj = longint'($signed(key_sp[j]));
    if (tj <= ti || t <= ti) return limit_speed(si);
    dt = tj - ti;
    u = ((t - ti) << 16) / dt;
    if (u > 65536) u = 65536;
    u2 = u * u;
    h = (u2 * (196608 - 2 * u)) >> 32;
    return limit_speed(si + (((sj - si) * longint'(h)) >>> 16));
  endfunction

  function automatic longint unsigned step_speed_sum(longint unsigned nsteps,
                                                     longint unsigned s, int n);
    longint unsigned c0, tl, kfirst, acc, k, t;
    c0 = curve_speed(key_tm[0], n);
    tl = key_tm[n-1];
    kfirst = key_tm[0] / s;
    if (kfirst >= nsteps) return (nsteps + 1) * c0;
    acc = (kfirst + 1) * c0;
    for (k = kfirst + 1; k <= nsteps; k++) begin
      t = k * s;
      if (t >= tl) begin
        return acc + (nsteps - k + 1) * curve_speed(tl, n);
      end
      acc += curve_speed(t, n);
    end
    return acc;
  endfunction

  function automatic ramp_result_t predict_query(longint unsigned qt, longint unsigned off);
    ramp_result_t r;
    int n;
    longint unsigned s, nsteps, rem, d, vn;
    n = (mdl_count > 8) ? 8 : int'(mdl_count);
    if (!mdl_enable || n == 0) begin
      r.spd = 21'd65536;
      r.src = 45'((off + qt) << 16);
      return r;
    end
    s = (mdl_step == 0) ? 1 : (mdl_step > 1000) ? 1000 : mdl_step;
    nsteps = qt / s;
    rem = qt - nsteps * s;
    d = 0;
    vn = curve_speed(nsteps * s, n);
    if (nsteps > 0)
      d = (2 * step_speed_sum(nsteps, s, n) - curve_speed(0, n) - vn) * s;
    if (rem > 0) d += (vn + curve_speed(qt, n)) * rem;
    r.spd = 21'(curve_speed(qt, n));
    r.src = 45'((off << 16) + (d >> 1));
    return r;
  endfunction

  always @(posedge clk) begin
    ramp_result_t exp_r;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no expectation: speed_now %0d source_time %0d",
               speed_now, source_time);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (speed_now !== exp_r.spd) begin
          $error("speed_now expected %0d actual %0d", exp_r.spd, speed_now);
          errors++;
        end
        if (source_time !== exp_r.src) begin
          $error("source_time expected %0d actual %0d", exp_r.src, source_time);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_item(logic o, logic [2:0] idx, logic [23:0] tm, logic [21:0] spd,
                           logic [23:0] qt, logic [23:0] off);
    @(negedge clk);
    start = 1'b1;
    op = o;
    point_index = idx;
    point_time_ms = tm;
    point_speed = spd;
    query_time_ms = qt;
    source_offset_ms = off;
    do @(posedge clk); while (busy);
    if (o == OP_WRITE) begin
      key_tm[idx] = tm;
      key_sp[idx] = spd;
    end else begin
      pending_results.push_back(predict_query(qt, off));
    end
    if ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      start = 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [9:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    case (idx)
      REG_ENABLE: mdl_enable = val[0];
      REG_COUNT:  mdl_count = val[3:0];
      REG_STEP:   mdl_step = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic load_ramp(longint unsigned base, longint unsigned span);
    logic [21:0] spd;
    for (int i = 0; i < 8; i++) begin
      spd = ($urandom_range(0, 1)) ? 22'($urandom_range(0, 1400000)) : 22'($urandom);
      send_item(OP_WRITE, 3'(i), 24'(base + (span * i) / 7), spd, 24'($urandom),
                24'($urandom));
    end
  endtask

  task automatic test_unity();
    send_item(OP_QUERY, 3'd0, 24'd0, 22'd0, 24'd0, 24'd0);
    send_item(OP_QUERY, 3'd7, 24'hFFFFFF, 22'h3FFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_item(OP_WRITE, 3'd7, 24'hFFFFFF, 22'h1FFFFF, 24'd0, 24'd0);
    send_item(OP_WRITE, 3'd0, 24'd0, 22'h200000, 24'hFFFFFF, 24'hFFFFFF);
    drain_results();
  endtask

  task automatic test_curve();
    for (int i = 0; i < 8; i++)
      send_item(OP_WRITE, 3'(i), 24'(100 + 10 * i), 22'(32768 * (i + 1)), 24'd0, 24'd0);
    drain_results();
    write_reg(REG_ENABLE, 10'h3FF);
    write_reg(REG_COUNT, 10'd8);
    write_reg(REG_STEP, 10'd1);
    send_item(OP_QUERY, 3'd0, 24'd0, 22'd0, 24'd0, 24'd5);
    send_item(OP_QUERY, 3'd0, 24'd0, 22'd0, 24'd50, 24'd0);
    send_item(OP_QUERY, 3'd0, 24'd0, 22'd0, 24'd120, 24'd0);
    send_item(OP_QUERY, 3'd0, 24'd0, 22'd0, 24'd137, 24'hFFFFFF);
    send_item(OP_QUERY, 3'd0, 24'd0, 22'd0, 24'hFFFFFF, 24'hFFFFFF);
    send_item(OP_WRITE, 3'd3, 24'd105, 22'h200000, 24'd0, 24'd0);
    send_item(OP_WRITE, 3'd4, 24'd140, 22'h1FFFFF, 24'd0, 24'd0);
    send_item(OP_QUERY, 3'd0, 24'd0, 22'd0, 24'd133, 24'd1);
    drain_results();
    write_reg(REG_COUNT, 10'h3FF);
    write_reg(REG_STEP, 10'd0);
    send_item(OP_QUERY, 3'd0, 24'd0, 22'd0, 24'd151, 24'd7);
    drain_results();
    write_reg(REG_COUNT, 10'd1);
    write_reg(REG_STEP, 10'h3FF);
    write_reg(REG_NONE, 10'h3FF);
    send_item(OP_QUERY, 3'd0, 24'd0, 22'd0, 24'd99999, 24'd3);
    drain_results();
    write_reg(REG_COUNT, 10'd0);
    send_item(OP_QUERY, 3'd0, 24'd0, 22'd0, 24'd1234, 24'd3);
    drain_results();
    write_reg(REG_ENABLE, 10'd0);
    write_reg(REG_STEP, 10'd1000);
  endtask

  task automatic test_random(int pct, int items);
    longint unsigned s, span, base, lo, qt;
    idle_pct = 0;
    drain_results();
    s = $urandom_range(0, 3) == 0 ? $urandom_range(1, 1023) : $urandom_range(1, 20);
    span = (s > 1000 ? 1000 : s) * $urandom_range(0, 30);
    base = $urandom_range(0, 3) == 0 ? $urandom_range(0, 500) : 24'($urandom);
    if (base + span > 24'hFFFFFF) base = 24'hFFFFFF - span;
    load_ramp(base, span);
    drain_results();
    write_reg(REG_ENABLE, 10'($urandom_range(0, 7) != 0));
    write_reg(REG_COUNT, 10'($urandom_range(1, 15)));
    write_reg(REG_STEP, 10'(s));
    idle_pct = pct;
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(0, 99) < 15) begin
        send_item(OP_WRITE, 3'($urandom), 24'(base + $urandom_range(0, span)),
                  22'($urandom), 24'($urandom), 24'($urandom));
      end else begin
        lo = (base > 2 * s) ? base - 2 * s : 0;
        qt = lo + $urandom_range(0, span + 4 * s);
        if (qt > 24'hFFFFFF || $urandom_range(0, 9) < 3) qt = 24'($urandom);
        send_item(OP_QUERY, 3'($urandom), 24'($urandom), 22'($urandom), 24'(qt),
                  24'($urandom));
      end
    end
    idle_pct = 0;
    drain_results();
  endtask

  task automatic test_pause();
    send_item(OP_QUERY, 3'd0, 24'd0, 22'd0, 24'($urandom), 24'($urandom));
    drain_results();
    send_item(OP_QUERY, 3'd0, 24'd0, 22'd0, 24'($urandom), 24'($urandom));
    drain_results();
  endtask

  initial begin
    errors = 0;
    idle_pct = 0;
    stall_cycles = 0;
    rst = 1'b1;
    start = 1'b0;
    op = OP_WRITE;
    point_index = '0;
    point_time_ms = '0;
    point_speed = '0;
    query_time_ms = '0;
    source_offset_ms = '0;
    cfg_we = 1'b0;
    cfg_index = REG_ENABLE;
    cfg_data = '0;
    mdl_enable = 1'b0;
    mdl_count = 4'd0;
    mdl_step = 10'd10;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_unity();
    test_curve();
    test_random(0, 12);
    test_random(68, 12);
    test_pause();
    test_random(0, 12);
    test_random(9, 12);
    drain_results();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
